// ===== design/ssnp_pkg.sv =====
// Shared types, constants and helper functions for the size suffix number parser.
// No dependencies; imported by the scan stage, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ssnp_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_MINUS,
    PH_DIGITS,
    PH_SUFFIX,
    PH_FAILED
  } ssnp_phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE
  } ssnp_status_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_BIG_B = 8'h42;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_K  = 8'h6B;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_G  = 8'h67;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [67:0] POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] NEG_LIMIT = 68'h0_8000_0000_0000_0000;

  // Parser state captured when a string closes
  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [63:0] mag;
    logic        dovf;
    logic [7:0]  count;
    logic [23:0] sfx;
    logic [1:0]  sseen;
  } ssnp_snap_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] expo;
  } ssnp_unit_t;

  function automatic ssnp_unit_t ssnp_unit(input logic [7:0] c);
    ssnp_unit_t u;
    logic [7:0] lc;
    lc = c | CASE_BIT;
    u.hit  = 1'b1;
    u.expo = 3'd0;
    case (lc)
      CH_LO_B: u.expo = 3'd0;
      CH_LO_K: u.expo = 3'd1;
      CH_LO_M: u.expo = 3'd2;
      CH_LO_G: u.expo = 3'd3;
      CH_LO_T: u.expo = 3'd4;
      default: u.hit = 1'b0;
    endcase
    return u;
  endfunction

  // 1000^e = 5^(3e) * 2^(3e)
  function automatic logic [27:0] ssnp_pow5(input logic [2:0] expo);
    logic [27:0] p;
    case (expo)
      3'd0:    p = 28'd1;
      3'd1:    p = 28'd125;
      3'd2:    p = 28'd15625;
      3'd3:    p = 28'd1953125;
      3'd4:    p = 28'd244140625;
      default: p = 28'd1;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] ssnp_shift(input logic dec, input logic [2:0] expo);
    logic [5:0] s;
    case (expo)
      3'd1:    s = dec ? 6'd3  : 6'd10;
      3'd2:    s = dec ? 6'd6  : 6'd20;
      3'd3:    s = dec ? 6'd9  : 6'd30;
      3'd4:    s = dec ? 6'd12 : 6'd40;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/ssnp_scan.sv =====
// Byte scanner: input register, parse state machine and closing snapshot register.
// Depends on ssnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_scan
  import ssnp_pkg::*;
#(
  parameter int MAX_LEN = 255
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_ch,
  input  wire        in_last,
  input  wire        in_no_char,
  output logic       snap_valid,
  input  wire        snap_ready,
  output ssnp_snap_t snap
);

  localparam int DCW = $clog2(MAX_LEN + 1);

  logic        i_v;
  logic [7:0]  i_ch;
  logic        i_last;
  logic        i_no_char;

  ssnp_phase_t phase, phase_next, phase_take;
  logic            neg, neg_next, neg_take;
  logic [63:0]     mag, mag_next, mag_take;
  logic            dovf, dovf_next, dovf_take;
  logic [DCW-1:0]  dcnt, dcnt_next, dcnt_take;
  logic [23:0]     sfx, sfx_next, sfx_take;
  logic [1:0]      sseen, sseen_next, sseen_take;

  logic        f_free;
  logic        pop;
  logic        is_digit;
  logic [3:0]  d;
  logic [67:0] acc;
  logic [67:0] limit;
  logic        take_dig;
  logic [16:0] cnt_ext;

  assign f_free   = !snap_valid || snap_ready;
  assign pop      = i_v && (!i_last || f_free);
  assign in_ready = !i_v || pop;

  assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
  assign d        = 4'(i_ch - CH_ZERO);
  assign limit    = neg ? NEG_LIMIT : POS_LIMIT;
  assign acc      = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + 68'(d);

  always_comb begin
    phase_take = phase;
    neg_take   = neg;
    mag_take   = mag;
    dovf_take  = dovf;
    dcnt_take  = dcnt;
    sfx_take   = sfx;
    sseen_take = sseen;
    take_dig   = 1'b0;
    if (!i_no_char) begin
      case (phase)
        PH_START: begin
          if (i_ch == CH_MINUS) begin
            neg_take   = 1'b1;
            phase_take = PH_AFTER_MINUS;
          end else if (is_digit) begin
            take_dig   = 1'b1;
            phase_take = PH_DIGITS;
          end else begin
            phase_take = PH_FAILED;
          end
        end
        PH_AFTER_MINUS: begin
          if (is_digit) begin
            take_dig   = 1'b1;
            phase_take = PH_DIGITS;
          end else begin
            phase_take = PH_FAILED;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            take_dig = 1'b1;
          end else begin
            sfx_take   = {16'b0, i_ch};
            sseen_take = 2'd1;
            phase_take = PH_SUFFIX;
          end
        end
        PH_SUFFIX: begin
          if (sseen == 2'd1) begin
            sfx_take[15:8] = i_ch;
            sseen_take     = 2'd2;
          end else if (sseen == 2'd2) begin
            sfx_take[23:16] = i_ch;
            sseen_take      = 2'd3;
          end
        end
        default: ;
      endcase
    end
    if (take_dig) begin
      if (!dovf) begin
        if (acc > limit) begin
          dovf_take = 1'b1;
        end else begin
          mag_take = acc[63:0];
        end
      end
      if (dcnt < DCW'(MAX_LEN)) begin
        dcnt_take = dcnt + 1'b1;
      end
    end

    phase_next = phase;
    neg_next   = neg;
    mag_next   = mag;
    dovf_next  = dovf;
    dcnt_next  = dcnt;
    sfx_next   = sfx;
    sseen_next = sseen;
    if (pop) begin
      if (i_last) begin
        phase_next = PH_START;
        neg_next   = 1'b0;
        mag_next   = '0;
        dovf_next  = 1'b0;
        dcnt_next  = '0;
        sfx_next   = '0;
        sseen_next = '0;
      end else begin
        phase_next = phase_take;
        neg_next   = neg_take;
        mag_next   = mag_take;
        dovf_next  = dovf_take;
        dcnt_next  = dcnt_take;
        sfx_next   = sfx_take;
        sseen_next = sseen_take;
      end
    end
  end

  assign cnt_ext = 17'(dcnt_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v        <= 1'b0;
      snap_valid <= 1'b0;
      neg        <= 1'b0;
      mag        <= '0;
      dovf       <= 1'b0;
      dcnt       <= '0;
      sfx        <= '0;
      sseen      <= '0;
    end else begin
      if (in_ready) begin
        i_v <= in_valid;
      end
      if (f_free) begin
        snap_valid <= pop && i_last;
      end
      neg   <= neg_next;
      mag   <= mag_next;
      dovf  <= dovf_next;
      dcnt  <= dcnt_next;
      sfx   <= sfx_next;
      sseen <= sseen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      i_ch      <= in_ch;
      i_last    <= in_last;
      i_no_char <= in_no_char;
    end
    if (pop && i_last) begin
      snap.ok    <= (phase_take == PH_DIGITS) || (phase_take == PH_SUFFIX);
      snap.neg   <= neg_take;
      snap.mag   <= mag_take;
      snap.dovf  <= dovf_take;
      snap.count <= (cnt_ext > 17'd255) ? 8'hFF : cnt_ext[7:0];
      snap.sfx   <= sfx_take;
      snap.sseen <= sseen_take;
    end
  end

endmodule

`default_nettype wire

// ===== design/size_suffix_number_parser_core.sv =====
// Top level of the size suffix number parser: scanner plus the scaling pipeline.
// Depends on ssnp_pkg and ssnp_scan.
`timescale 1ns / 1ps
`default_nettype none

// Parses a string streamed one byte per item into a signed 64-bit value with an
// optional k/m/g/t/b size suffix (bare or iB: powers of 1024, B: powers of 1000).
// One item is taken every cycle unless a closing item waits on a full snapshot
// register; bytes that do not close a string keep flowing while a result waits at
// the output. A closed string passes the scanner's snapshot register, then suffix
// decode with a 64x28 multiply split into two 32-bit partial products, the
// partial-product sum, and the final shift, range check and sign.

module size_suffix_number_parser_core
  import ssnp_pkg::*;
#(
  parameter int MAX_LEN = 255
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // ch
  input  wire         s_axis_tuser,   // no_char
  input  wire         s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // value[63:0], consumed[71:64]
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int CONS_CAP = (MAX_LEN < 255) ? MAX_LEN : 255;

  logic       f_v;
  logic       rdy_m;
  ssnp_snap_t f;

  ssnp_scan #(
    .MAX_LEN(MAX_LEN)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_ch     (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .in_no_char(s_axis_tuser),
    .snap_valid(f_v),
    .snap_ready(rdy_m),
    .snap      (f)
  );

  // decode stage
  ssnp_unit_t   unit;
  logic         has_sfx, is_ib, is_dec, hit;
  logic [2:0]   expo;
  logic [1:0]   slen;
  logic [8:0]   cons_sum;
  logic [7:0]   cons_next;
  logic [27:0]  mult;
  ssnp_status_t st_next;
  logic         fix_next;
  logic [63:0]  fixval_next;

  logic         m_v;
  ssnp_status_t m_status;
  logic         m_fix;
  logic [63:0]  m_fixval;
  logic         m_neg;
  logic         m_chk;
  logic [5:0]   m_shift;
  logic [7:0]   m_cons;
  logic [59:0]  m_pp_lo;
  logic [59:0]  m_pp_hi;

  logic         s_v;
  ssnp_status_t s_status;
  logic         s_fix;
  logic [63:0]  s_fixval;
  logic         s_neg;
  logic         s_chk;
  logic [5:0]   s_shift;
  logic [7:0]   s_cons;
  logic [91:0]  s_p5;

  logic         o_v;
  ssnp_status_t o_status;
  logic [63:0]  o_value;
  logic [7:0]   o_cons;

  logic         rdy_o, rdy_s;
  logic         ovf;
  logic [63:0]  prod;
  logic [6:0]   ovf_pos;

  assign rdy_o = !o_v || m_axis_tready;
  assign rdy_s = !s_v || rdy_o;
  assign rdy_m = !m_v || rdy_s;

  assign unit    = ssnp_unit(f.sfx[7:0]);
  assign has_sfx = (f.sseen != 2'd0);
  assign is_ib   = (f.sseen == 2'd3) && (f.sfx[15:8] == CH_I) && (f.sfx[23:16] == CH_BIG_B);
  assign is_dec  = !is_ib && (f.sseen >= 2'd2) && (f.sfx[15:8] == CH_BIG_B);
  assign hit     = has_sfx && unit.hit;
  assign expo    = hit ? unit.expo : 3'd0;
  assign slen    = !hit ? 2'd0 : (is_ib ? 2'd3 : (is_dec ? 2'd2 : 2'd1));
  assign cons_sum  = 9'(f.count) + 9'(f.neg) + 9'(slen);
  assign cons_next = (cons_sum > 9'(CONS_CAP)) ? 8'(CONS_CAP) : cons_sum[7:0];
  assign mult    = is_dec ? ssnp_pow5(expo) : 28'd1;

  always_comb begin
    st_next     = ST_OK;
    fix_next    = 1'b0;
    fixval_next = '0;
    if (!f.ok) begin
      st_next  = ST_NO_DIGITS;
      fix_next = 1'b1;
    end else if (f.dovf) begin
      st_next     = ST_RANGE;
      fix_next    = 1'b1;
      fixval_next = f.neg ? '1 : 64'd1;
    end else if (hit && f.neg && (f.mag != '0)) begin
      st_next     = ST_RANGE;
      fix_next    = 1'b1;
      fixval_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
      s_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (rdy_m) begin
        m_v <= f_v;
      end
      if (rdy_s) begin
        s_v <= m_v;
      end
      if (rdy_o) begin
        o_v <= s_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m && f_v) begin
      m_status <= st_next;
      m_fix    <= fix_next;
      m_fixval <= fixval_next;
      m_neg    <= f.neg;
      m_chk    <= hit;
      m_shift  <= ssnp_shift(is_dec, expo);
      m_cons   <= f.ok ? cons_next : 8'd0;
      m_pp_lo  <= f.mag[31:0] * mult;
      m_pp_hi  <= f.mag[63:32] * mult;
    end
    if (rdy_s && m_v) begin
      s_status <= m_status;
      s_fix    <= m_fix;
      s_fixval <= m_fixval;
      s_neg    <= m_neg;
      s_chk    <= m_chk;
      s_shift  <= m_shift;
      s_cons   <= m_cons;
      s_p5     <= 92'(m_pp_lo) + (92'(m_pp_hi) << 32);
    end
    if (rdy_o && s_v) begin
      o_cons <= s_cons;
      if (s_fix) begin
        o_status <= s_status;
        o_value  <= s_fixval;
      end else if (ovf) begin
        o_status <= ST_RANGE;
        o_value  <= 64'd1;
      end else begin
        o_status <= s_status;
        o_value  <= s_neg ? (~prod + 64'd1) : prod;
      end
    end
  end

  assign ovf_pos = 7'd63 - 7'(s_shift);
  assign ovf     = s_chk && ((s_p5 >> ovf_pos) != '0);
  assign prod    = s_p5[63:0] << s_shift;

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {o_cons, o_value};
  assign m_axis_tuser  = o_status;

endmodule

`default_nettype wire

// ===== design/ssnp_check.sv =====
// Port-level checker for the size suffix number parser, bound to the top level.
// Depends on ssnp_pkg and size_suffix_number_parser_core.
`timescale 1ns / 1ps
`default_nettype none

module ssnp_check
  import ssnp_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [71:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  a_nodig_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_NO_DIGITS)) |-> (m_axis_tdata == '0))
    else $error("no-digit item carries nonzero value or count");

  a_range_unit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_RANGE)) |->
      ((m_axis_tdata[63:0] == 64'd1) || (m_axis_tdata[63:0] == 64'hFFFF_FFFF_FFFF_FFFF)))
    else $error("out-of-range item value is not plus or minus one");

  a_ok_counted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_OK)) |-> (m_axis_tdata[71:64] != 8'd0))
    else $error("parsed item reports zero bytes consumed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output item changed");

endmodule

bind size_suffix_number_parser_core ssnp_check u_ssnp_check (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
